### hdl/bprf_pkg.sv
`default_nettype none

package bprf_pkg;

   typedef enum logic [2:0] {
      CMD_FILL_SET = 3'd0,
      CMD_FILL_CLR = 3'd1,
      CMD_OUTLINE  = 3'd2,
      CMD_CLEAR    = 3'd3,
      CMD_READ     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_SET,
      OP_CLR
   } plane_op_type;

   typedef enum logic [1:0] {
      EDGE_TOP    = 2'd0,
      EDGE_BOTTOM = 2'd1,
      EDGE_LEFT   = 2'd2,
      EDGE_RIGHT  = 2'd3
   } edge_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SPAN_START,
      S_SPAN_RUN,
      S_RMW_WR,
      S_RD,
      S_RD_WAIT,
      S_WIPE,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_CLIP,
      W_ADDR,
      W_RUN
   } walk_state_type;

   // one horizontal or vertical run: coord_a..coord_b along, fixed across
   typedef struct packed {
      logic               is_col;
      logic signed [15:0] coord_a;
      logic signed [15:0] coord_b;
      logic signed [15:0] fixed;
   } span_type;

   typedef struct packed {
      logic busy;
      logic valid;
   } walk_stat_type;

   localparam logic [7:0] FULL_MASK = 8'hFF;
   localparam logic [7:0] MSB_MASK  = 8'h80;

   function automatic logic [7:0] apply_mask(plane_op_type op, logic [7:0] cur,
                                             logic [7:0] m);
      logic [7:0] res;
      unique case (op)
         OP_SET:  res = cur | m;
         OP_CLR:  res = cur & ~m;
         default: res = cur;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

### hdl/bprf_ram.sv
`default_nettype none

module bprf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 3840,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hdl/bprf_walk.sv
`default_nettype none

module bprf_walk #(
   parameter int PLANE_WIDTH  = 240,
   parameter int PLANE_HEIGHT = 128,
   parameter int ROW_BYTES    = 30,
   parameter int ADDR_W       = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire bprf_pkg::span_type      span,
   input  wire logic                    advance,
   output bprf_pkg::walk_stat_type      stat,
   output logic        [ADDR_W-1:0]     byte_addr,
   output logic        [7:0]            byte_mask
);

   localparam int DRAW_W  = (PLANE_WIDTH < ROW_BYTES * 8) ? PLANE_WIDTH : ROW_BYTES * 8;
   localparam int MAX_DIM = (DRAW_W > PLANE_HEIGHT) ? DRAW_W : PLANE_HEIGHT;
   localparam int CW      = $clog2(MAX_DIM);

   bprf_pkg::walk_state_type state_ff, state_in;
   bprf_pkg::span_type       req_ff, req_in;
   logic [CW-1:0]     lo_ff, lo_in, hi_ff, hi_in, fixed_ff, fixed_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, step_ff, step_in;
   logic [7:0]        mfirst_ff, mfirst_in, mlast_ff, mlast_in, mmid_ff, mmid_in;
   logic              first_ff, first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bprf_pkg::W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff    <= req_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      fixed_ff  <= fixed_in;
      rem_ff    <= rem_in;
      addr_ff   <= addr_in;
      step_ff   <= step_in;
      mfirst_ff <= mfirst_in;
      mlast_ff  <= mlast_in;
      mmid_ff   <= mmid_in;
      first_ff  <= first_in;
   end

   always_comb begin
      int   lo, hi, fx, lim_along, lim_fixed;
      logic empty;
      state_in  = state_ff;
      req_in    = req_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      fixed_in  = fixed_ff;
      rem_in    = rem_ff;
      addr_in   = addr_ff;
      step_in   = step_ff;
      mfirst_in = mfirst_ff;
      mlast_in  = mlast_ff;
      mmid_in   = mmid_ff;
      first_in  = first_ff;

      // clip: order the ends, drop a run wholly off the plane, clamp the rest
      lo = (req_ff.coord_b < req_ff.coord_a) ? int'(req_ff.coord_b) : int'(req_ff.coord_a);
      hi = (req_ff.coord_b < req_ff.coord_a) ? int'(req_ff.coord_a) : int'(req_ff.coord_b);
      fx = int'(req_ff.fixed);
      lim_along = req_ff.is_col ? PLANE_HEIGHT : DRAW_W;
      lim_fixed = req_ff.is_col ? DRAW_W : PLANE_HEIGHT;
      empty = (fx < 0) || (fx >= lim_fixed) || (hi < 0) || (lo > lim_along - 1);
      if (lo < 0) begin
         lo = 0;
      end
      if (hi > lim_along - 1) begin
         hi = lim_along - 1;
      end

      unique case (state_ff)
         bprf_pkg::W_IDLE: begin
            if (start) begin
               req_in   = span;
               state_in = bprf_pkg::W_CLIP;
            end
         end
         bprf_pkg::W_CLIP: begin
            lo_in    = CW'(lo);
            hi_in    = CW'(hi);
            fixed_in = CW'(fx);
            state_in = empty ? bprf_pkg::W_IDLE : bprf_pkg::W_ADDR;
         end
         bprf_pkg::W_ADDR: begin
            first_in = 1'b1;
            if (req_ff.is_col) begin
               addr_in   = ADDR_W'(lo_ff) * ADDR_W'(ROW_BYTES) + ADDR_W'(fixed_ff >> 3);
               rem_in    = hi_ff - lo_ff;
               step_in   = ADDR_W'(ROW_BYTES);
               mmid_in   = bprf_pkg::MSB_MASK >> fixed_ff[2:0];
               mfirst_in = bprf_pkg::FULL_MASK;
               mlast_in  = bprf_pkg::FULL_MASK;
            end else begin
               addr_in   = ADDR_W'(fixed_ff) * ADDR_W'(ROW_BYTES) + ADDR_W'(lo_ff >> 3);
               rem_in    = (hi_ff >> 3) - (lo_ff >> 3);
               step_in   = ADDR_W'(1);
               mmid_in   = bprf_pkg::FULL_MASK;
               mfirst_in = bprf_pkg::FULL_MASK >> lo_ff[2:0];
               mlast_in  = bprf_pkg::FULL_MASK << (3'd7 - hi_ff[2:0]);
            end
            state_in = bprf_pkg::W_RUN;
         end
         bprf_pkg::W_RUN: begin
            if (advance) begin
               if (rem_ff == '0) begin
                  state_in = bprf_pkg::W_IDLE;
               end else begin
                  addr_in  = addr_ff + step_ff;
                  rem_in   = rem_ff - CW'(1);
                  first_in = 1'b0;
               end
            end
         end
         default: state_in = bprf_pkg::W_IDLE;
      endcase
   end

   assign stat.busy  = (state_ff != bprf_pkg::W_IDLE);
   assign stat.valid = (state_ff == bprf_pkg::W_RUN);
   assign byte_addr  = addr_ff;
   assign byte_mask  = mmid_ff
                     & (first_ff ? mfirst_ff : bprf_pkg::FULL_MASK)
                     & ((rem_ff == '0) ? mlast_ff : bprf_pkg::FULL_MASK);

endmodule

`default_nettype wire

### hdl/bitplane_rect_fill_outline_unit.sv
`default_nettype none

// Two-plane 1 bpp drawing engine. Commands arrive one transaction at a time on
// req_ and each returns one byte on rsp_ (the read byte, zero otherwise).
// Every pixel update is a read-modify-write through the single port of the
// plane memory. A span that clips to nothing writes no byte; a fill walks one
// span per clipped row, an outline four spans with both planes written side by
// side. Clear wipes both planes. After reset a clearing pass over all
// PLANE_BYTES bytes (3840 by default) runs with req_tready low. One command is
// in work at a time; a finished result waits in the output register while the
// next is accepted.
module bitplane_rect_fill_outline_unit #(
   parameter int PLANE_WIDTH  = 240,
   parameter int PLANE_HEIGHT = 128,
   parameter int ROW_BYTES    = 30
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_first[15:0], y_first[31:16], x_second[47:32], y_second[63:48],
   // gray_color[65:64], byte_address[77:66], zero[79:78]
   input  wire logic [79:0] req_tdata,
   // command[2:0], plane_select[3]
   input  wire logic [3:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0]
   output logic      [7:0]  rsp_tdata
);

   localparam int PLANE_BYTES = ROW_BYTES * PLANE_HEIGHT;
   localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
   localparam int YW          = $clog2(PLANE_HEIGHT + 1);

   logic signed [15:0] in_x1, in_y1, in_x2, in_y2;
   logic        [1:0]  in_color;
   logic        [11:0] in_addr;
   bprf_pkg::cmd_type  in_cmd;
   logic               in_plane;

   assign in_x1    = req_tdata[15:0];
   assign in_y1    = req_tdata[31:16];
   assign in_x2    = req_tdata[47:32];
   assign in_y2    = req_tdata[63:48];
   assign in_color = req_tdata[65:64];
   assign in_addr  = req_tdata[77:66];
   assign in_cmd   = bprf_pkg::cmd_type'(req_tuser[2:0]);
   assign in_plane = req_tuser[3];

   bprf_pkg::state_type    state_ff, state_in;
   bprf_pkg::plane_op_type light_op_ff, light_op_in, dark_op_ff, dark_op_in;
   bprf_pkg::edge_type     edge_ff, edge_in;
   logic signed [15:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic               outline_ff, outline_in, plane_ff, plane_in;
   logic [YW-1:0]      ycur_ff, ycur_in, yhi_ff, yhi_in;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in, wipe_ff, wipe_in;
   logic [7:0]         data_ff, data_in, rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0]       mem_addr, walk_addr;
   logic                    light_we, dark_we;
   logic [7:0]              light_wdata, dark_wdata, light_rdata, dark_rdata, walk_mask;
   logic                    walk_start, walk_advance;
   bprf_pkg::span_type      span;
   bprf_pkg::walk_stat_type walk_stat;

   // fill row range, clipped to the plane
   int   fy_lo, fy_hi;
   logic fill_empty;

   always_comb begin
      fy_lo = (in_y2 < in_y1) ? int'(in_y2) : int'(in_y1);
      fy_hi = (in_y2 < in_y1) ? int'(in_y1) : int'(in_y2);
      fill_empty = (fy_hi < 0) || (fy_lo > PLANE_HEIGHT - 1);
      if (fy_lo < 0) begin
         fy_lo = 0;
      end
      if (fy_hi > PLANE_HEIGHT - 1) begin
         fy_hi = PLANE_HEIGHT - 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bprf_pkg::S_INIT;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      light_op_ff <= light_op_in;
      dark_op_ff  <= dark_op_in;
      edge_ff     <= edge_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      outline_ff  <= outline_in;
      plane_ff    <= plane_in;
      ycur_ff     <= ycur_in;
      yhi_ff      <= yhi_in;
      rd_addr_ff  <= rd_addr_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      span.coord_a = x1_ff;
      span.coord_b = x2_ff;
      span.is_col  = 1'b0;
      span.fixed   = 16'(ycur_ff);
      if (outline_ff) begin
         unique case (edge_ff)
            bprf_pkg::EDGE_TOP:    span.fixed = y1_ff;
            bprf_pkg::EDGE_BOTTOM: span.fixed = y2_ff;
            bprf_pkg::EDGE_LEFT: begin
               span.is_col  = 1'b1;
               span.coord_a = y1_ff;
               span.coord_b = y2_ff;
               span.fixed   = x1_ff;
            end
            bprf_pkg::EDGE_RIGHT: begin
               span.is_col  = 1'b1;
               span.coord_a = y1_ff;
               span.coord_b = y2_ff;
               span.fixed   = x2_ff;
            end
            default: span.fixed = y1_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      light_op_in  = light_op_ff;
      dark_op_in   = dark_op_ff;
      edge_in      = edge_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      outline_in   = outline_ff;
      plane_in     = plane_ff;
      ycur_in      = ycur_ff;
      yhi_in       = yhi_ff;
      rd_addr_in   = rd_addr_ff;
      wipe_in      = wipe_ff;
      data_in      = data_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      walk_start   = 1'b0;
      walk_advance = 1'b0;
      mem_addr     = walk_addr;
      light_we     = 1'b0;
      dark_we      = 1'b0;
      light_wdata  = bprf_pkg::apply_mask(light_op_ff, light_rdata, walk_mask);
      dark_wdata   = bprf_pkg::apply_mask(dark_op_ff, dark_rdata, walk_mask);

      unique case (state_ff)
         bprf_pkg::S_INIT, bprf_pkg::S_WIPE: begin
            mem_addr    = wipe_ff;
            light_we    = 1'b1;
            dark_we     = 1'b1;
            light_wdata = '0;
            dark_wdata  = '0;
            wipe_in     = wipe_ff + ADDR_W'(1);
            if (wipe_ff == ADDR_W'(PLANE_BYTES - 1)) begin
               state_in = (state_ff == bprf_pkg::S_INIT) ? bprf_pkg::S_IDLE
                                                         : bprf_pkg::S_DONE;
            end
         end
         bprf_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x1_in      = in_x1;
               y1_in      = in_y1;
               x2_in      = in_x2;
               y2_in      = in_y2;
               plane_in   = in_plane;
               outline_in = 1'b0;
               edge_in    = bprf_pkg::EDGE_TOP;
               ycur_in    = YW'(fy_lo);
               yhi_in     = YW'(fy_hi);
               rd_addr_in = ADDR_W'(in_addr);
               data_in    = '0;
               light_op_in = bprf_pkg::OP_NONE;
               dark_op_in  = bprf_pkg::OP_NONE;
               unique case (in_cmd)
                  bprf_pkg::CMD_FILL_SET, bprf_pkg::CMD_FILL_CLR: begin
                     if (in_plane) begin
                        dark_op_in = (in_cmd == bprf_pkg::CMD_FILL_SET) ? bprf_pkg::OP_SET
                                                                        : bprf_pkg::OP_CLR;
                     end else begin
                        light_op_in = (in_cmd == bprf_pkg::CMD_FILL_SET) ? bprf_pkg::OP_SET
                                                                         : bprf_pkg::OP_CLR;
                     end
                     state_in = fill_empty ? bprf_pkg::S_DONE : bprf_pkg::S_SPAN_START;
                  end
                  bprf_pkg::CMD_OUTLINE: begin
                     outline_in  = 1'b1;
                     light_op_in = in_color[0] ? bprf_pkg::OP_SET : bprf_pkg::OP_CLR;
                     dark_op_in  = in_color[1] ? bprf_pkg::OP_SET : bprf_pkg::OP_CLR;
                     state_in    = bprf_pkg::S_SPAN_START;
                  end
                  bprf_pkg::CMD_CLEAR: begin
                     wipe_in  = '0;
                     state_in = bprf_pkg::S_WIPE;
                  end
                  bprf_pkg::CMD_READ: begin
                     state_in = (32'(in_addr) < 32'(PLANE_BYTES)) ? bprf_pkg::S_RD
                                                                  : bprf_pkg::S_DONE;
                  end
                  default: state_in = bprf_pkg::S_DONE;
               endcase
            end
         end
         bprf_pkg::S_SPAN_START: begin
            walk_start = 1'b1;
            state_in   = bprf_pkg::S_SPAN_RUN;
         end
         bprf_pkg::S_SPAN_RUN: begin
            if (walk_stat.valid) begin
               state_in = bprf_pkg::S_RMW_WR;
            end else if (!walk_stat.busy) begin
               if (outline_ff) begin
                  if (edge_ff == bprf_pkg::EDGE_RIGHT) begin
                     state_in = bprf_pkg::S_DONE;
                  end else begin
                     edge_in  = bprf_pkg::edge_type'(edge_ff + 2'd1);
                     state_in = bprf_pkg::S_SPAN_START;
                  end
               end else if (ycur_ff == yhi_ff) begin
                  state_in = bprf_pkg::S_DONE;
               end else begin
                  ycur_in  = ycur_ff + YW'(1);
                  state_in = bprf_pkg::S_SPAN_START;
               end
            end
         end
         bprf_pkg::S_RMW_WR: begin
            light_we     = (light_op_ff != bprf_pkg::OP_NONE);
            dark_we      = (dark_op_ff != bprf_pkg::OP_NONE);
            walk_advance = 1'b1;
            state_in     = bprf_pkg::S_SPAN_RUN;
         end
         bprf_pkg::S_RD: begin
            mem_addr = rd_addr_ff;
            state_in = bprf_pkg::S_RD_WAIT;
         end
         bprf_pkg::S_RD_WAIT: begin
            data_in  = plane_ff ? dark_rdata : light_rdata;
            state_in = bprf_pkg::S_DONE;
         end
         bprf_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff;
               state_in     = bprf_pkg::S_IDLE;
            end
         end
         default: state_in = bprf_pkg::S_IDLE;
      endcase
   end

   bprf_walk #(
      .PLANE_WIDTH  (PLANE_WIDTH),
      .PLANE_HEIGHT (PLANE_HEIGHT),
      .ROW_BYTES    (ROW_BYTES),
      .ADDR_W       (ADDR_W)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .span      (span),
      .advance   (walk_advance),
      .stat      (walk_stat),
      .byte_addr (walk_addr),
      .byte_mask (walk_mask)
   );

   bprf_ram #(
      .WIDTH  (8),
      .DEPTH  (PLANE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_light (
      .clock (clock),
      .we    (light_we),
      .addr  (mem_addr),
      .wdata (light_wdata),
      .rdata (light_rdata)
   );

   bprf_ram #(
      .WIDTH  (8),
      .DEPTH  (PLANE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_dark (
      .clock (clock),
      .we    (dark_we),
      .addr  (mem_addr),
      .wdata (dark_wdata),
      .rdata (dark_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bprf_pkg::S_IDLE) |-> (!light_we && !dark_we))
      else $error("plane written while idle");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (light_we || dark_we) |-> (32'(mem_addr) < 32'(PLANE_BYTES)))
      else $error("plane write beyond plane size");

   a_walk_owned: assert property (@(posedge clock) disable iff (reset)
      walk_stat.valid |-> (state_ff == bprf_pkg::S_SPAN_RUN ||
                           state_ff == bprf_pkg::S_RMW_WR))
      else $error("span walker active outside span states");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == bprf_pkg::S_DONE))
      else $error("result raised without a finished command");
`endif

endmodule

`default_nettype wire
